// File: rtl/bal_pkg.sv
// Shared definitions for the bounded array list block.
// Holds sizes, request and status codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

  // List capacity and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths of the request and response.
  localparam int VAL_W   = 32;
  localparam int POS_W   = 7;
  localparam int OP_W    = 4;
  localparam int STAT_W  = 3;
  localparam int FIDX_W  = 6;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 24;

  // Request codes.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK    = 4'd0,
    OP_POP_BACK     = 4'd1,
    OP_PUSH_FRONT   = 4'd2,
    OP_POP_FRONT    = 4'd3,
    OP_INSERT       = 4'd4,
    OP_ERASE        = 4'd5,
    OP_FIND         = 4'd6,
    OP_REMOVE_FIRST = 4'd7,
    OP_REMOVE_ALL   = 4'd8,
    OP_CLEAR        = 4'd9
  } op_t;

  // Response status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_SHIFT_UP = 6'b000010,
    S_SHIFT_DN = 6'b000100,
    S_SCAN     = 6'b001000,
    S_COMPACT  = 6'b010000,
    S_RESP     = 6'b100000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/bal_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bal_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/bounded_array_list_top.sv
// Bounded array list: ordered list of signed 32-bit values held in one RAM.
// Depends on bal_pkg and bal_ram.
//
// Usage:
//   Requests arrive on the s_ stream: s_tuser carries the operation code and
//   s_tdata the value and position. One response per request leaves on the
//   m_ stream with status, found index, found flag and the new entry count.
//   The block takes one request at a time; s_tready is high only while the
//   sequencer is idle, also while an earlier response waits in the output
//   register.
//   Steps from request accepted to response accepted:
//     pop_back, clear, error cases and unused codes: straight to the response.
//     push, insert, erase and pop_front: entries moved one place, then response.
//     find and remove_first: entries read until a match or the end of the list;
//     remove_first then moves the entries after the match down one place.
//     remove_all: every entry read once, survivors packed towards the front.
//   The RAM port moves or compares one entry per cycle.
//   Reset empties the list at once; the RAM contents are not cleared, as
//   only entries below the count are ever read.
//   If the receiver stalls, the response is held and the next request is
//   taken, but its response waits until the output register is free.
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_list_top
  import bal_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // value [31:0], position [38:32], zero fill
  input  wire logic [OP_W-1:0]  s_tuser,   // op [3:0]
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata    // status [2:0], found_index [8:3], found [9],
                                           // count [16:10], zero fill
);

  // Sequencer and list state.
  state_t              state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [CNT_W-1:0]    k, k_next;
  logic [CNT_W-1:0]    w, w_next;
  logic                pv, pv_next;
  logic [IDX_W-1:0]    pa, pa_next;

  // Request held during the walk.
  op_t                 op_r, op_next;
  logic [VAL_W-1:0]    val_r, val_next;
  logic [POS_W-1:0]    pos_r, pos_next;

  // Response being built and response register.
  status_t             st_r, st_next;
  logic [FIDX_W-1:0]   fidx_r, fidx_next;
  logic                found_r, found_next;
  logic                out_valid, out_valid_next;
  status_t             out_status;
  logic [FIDX_W-1:0]   out_fidx;
  logic                out_found;
  logic [CNT_W-1:0]    out_count;
  logic                out_load;

  // RAM port signals.
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [VAL_W-1:0]    ram_wdata;
  logic [IDX_W-1:0]    ram_raddr;
  logic [VAL_W-1:0]    ram_rdata;

  // Request field views.
  op_t                 in_op;
  logic [VAL_W-1:0]    in_val;
  logic [POS_W-1:0]    in_pos;
  logic                full;
  logic                empty;
  logic [CNT_W-1:0]    k_dec;
  logic                match;

  assign in_op   = op_t'(s_tuser);
  assign in_val  = s_tdata[VAL_W-1:0];
  assign in_pos  = s_tdata[VAL_W+POS_W-1:VAL_W];
  assign full    = (cnt >= CNT_W'(CAPACITY));
  assign empty   = (cnt == '0);
  assign k_dec   = k - 1'b1;
  assign match   = (ram_rdata == val_r);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_W - STAT_W - FIDX_W - 1 - CNT_W){1'b0}},
                     out_count, out_found, out_fidx, out_status};

  // Entry storage.
  bal_ram #(
    .Width (VAL_W),
    .Depth (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer: while walking the list, one RAM read issued and one result consumed per cycle.
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    k_next         = k;
    w_next         = w;
    pv_next        = pv;
    pa_next        = pa;
    op_next        = op_r;
    val_next       = val_r;
    pos_next       = pos_r;
    st_next        = st_r;
    fidx_next      = fidx_r;
    found_next     = found_r;
    out_valid_next = out_valid && !m_tready;
    out_load       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = val_r;
    ram_raddr      = k[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_next    = in_op;
          val_next   = in_val;
          pos_next   = in_pos;
          st_next    = ST_OK;
          fidx_next  = '0;
          found_next = 1'b0;
          pv_next    = 1'b0;
          w_next     = '0;
          state_next = S_RESP;
          case (in_op)
            OP_PUSH_BACK: begin
              if (full) begin
                st_next = ST_FULL;
              end else begin
                pos_next   = cnt;
                k_next     = cnt;
                state_next = S_SHIFT_UP;
              end
            end
            OP_POP_BACK: begin
              if (empty) st_next = ST_EMPTY;
              else cnt_next = cnt - 1'b1;
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                st_next = ST_FULL;
              end else begin
                pos_next   = '0;
                k_next     = cnt;
                state_next = S_SHIFT_UP;
              end
            end
            OP_POP_FRONT: begin
              if (empty) begin
                st_next = ST_EMPTY;
              end else begin
                pos_next   = '0;
                k_next     = CNT_W'(1);
                state_next = S_SHIFT_DN;
              end
            end
            OP_INSERT: begin
              if (full) begin
                st_next = ST_FULL;
              end else if (in_pos > cnt) begin
                st_next = ST_BADPOS;
              end else begin
                k_next     = cnt;
                state_next = S_SHIFT_UP;
              end
            end
            OP_ERASE: begin
              if (empty) begin
                st_next = ST_EMPTY;
              end else if (in_pos >= cnt) begin
                st_next = ST_BADPOS;
              end else begin
                k_next     = in_pos + 1'b1;
                state_next = S_SHIFT_DN;
              end
            end
            OP_FIND: begin
              k_next     = '0;
              state_next = S_SCAN;
            end
            OP_REMOVE_FIRST: begin
              if (empty) begin
                st_next = ST_EMPTY;
              end else begin
                k_next     = '0;
                state_next = S_SCAN;
              end
            end
            OP_REMOVE_ALL: begin
              if (empty) begin
                st_next = ST_EMPTY;
              end else begin
                k_next     = '0;
                state_next = S_COMPACT;
              end
            end
            OP_CLEAR: begin
              cnt_next = '0;
            end
            default: begin
            end
          endcase
        end
      end

      // Move entries one place up, from the end down to the gap.
      S_SHIFT_UP: begin
        if (pv) begin
          ram_we    = 1'b1;
          ram_waddr = pa + 1'b1;
          ram_wdata = ram_rdata;
        end else if (k == pos_r) begin
          ram_we     = 1'b1;
          ram_waddr  = pos_r[IDX_W-1:0];
          ram_wdata  = val_r;
          cnt_next   = cnt + 1'b1;
          state_next = S_RESP;
        end
        if (k > pos_r) begin
          ram_raddr = k_dec[IDX_W-1:0];
          pa_next   = k_dec[IDX_W-1:0];
          k_next    = k_dec;
          pv_next   = 1'b1;
        end else begin
          pv_next = 1'b0;
        end
      end

      // Move entries one place down to close the gap.
      S_SHIFT_DN: begin
        if (pv) begin
          ram_we    = 1'b1;
          ram_waddr = pa - 1'b1;
          ram_wdata = ram_rdata;
        end
        if (k < cnt) begin
          ram_raddr = k[IDX_W-1:0];
          pa_next   = k[IDX_W-1:0];
          k_next    = k + 1'b1;
          pv_next   = 1'b1;
        end else begin
          pv_next = 1'b0;
          if (!pv) begin
            cnt_next   = cnt - 1'b1;
            state_next = S_RESP;
          end
        end
      end

      // Search for the first match; remove_first then closes the gap.
      S_SCAN: begin
        if (pv && match) begin
          found_next = 1'b1;
          pv_next    = 1'b0;
          if (op_r == OP_FIND) begin
            fidx_next  = pa;
            state_next = S_RESP;
          end else begin
            k_next     = CNT_W'(pa) + 1'b1;
            state_next = S_SHIFT_DN;
          end
        end else if (k < cnt) begin
          ram_raddr = k[IDX_W-1:0];
          pa_next   = k[IDX_W-1:0];
          k_next    = k + 1'b1;
          pv_next   = 1'b1;
        end else begin
          pv_next = 1'b0;
          if (!pv) begin
            st_next    = ST_NOTFOUND;
            state_next = S_RESP;
          end
        end
      end

      // Keep non-matching entries, packing them towards the front.
      S_COMPACT: begin
        if (pv && !match) begin
          ram_we    = 1'b1;
          ram_waddr = w[IDX_W-1:0];
          ram_wdata = ram_rdata;
          w_next    = w + 1'b1;
        end
        if (k < cnt) begin
          ram_raddr = k[IDX_W-1:0];
          pa_next   = k[IDX_W-1:0];
          k_next    = k + 1'b1;
          pv_next   = 1'b1;
        end else begin
          pv_next = 1'b0;
          if (!pv) begin
            if (w == cnt) begin
              st_next = ST_NOTFOUND;
            end else begin
              found_next = 1'b1;
              cnt_next   = w;
            end
            state_next = S_RESP;
          end
        end
      end

      // Hand the response to the output register once it is free.
      S_RESP: begin
        if (!out_valid || m_tready) begin
          out_load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pv        <= pv_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    k       <= k_next;
    w       <= w_next;
    pa      <= pa_next;
    op_r    <= op_next;
    val_r   <= val_next;
    pos_r   <= pos_next;
    st_r    <= st_next;
    fidx_r  <= fidx_next;
    found_r <= found_next;
    if (out_load) begin
      out_status <= st_r;
      out_fidx   <= fidx_r;
      out_found  <= found_r;
      out_count  <= cnt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/bal_checker.sv
// Port-level checks for the bounded array list, bound to the top level.
// Depends on bal_pkg and bounded_array_list_top.
`timescale 1ns / 1ps
`default_nettype none

module bal_checker
  import bal_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             s_tvalid,
  input wire logic             s_tready,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  // A stalled response holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("response changed while stalled");

  // A request is taken one at a time: the block is busy the cycle after.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // The reported count never exceeds the capacity.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[16:10] <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  // A match always comes with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tdata[2:0] == ST_OK)
    else $error("found with error status");

  // The index is zero unless a match was reported.
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[9] |-> m_tdata[8:3] == '0)
    else $error("index set without match");

endmodule

bind bounded_array_list_top bal_checker u_bal_checker (.*);

`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the bounded array list block.
// Drives requests, predicts every response in SystemVerilog and compares them.
// Depends on bal_pkg and bounded_array_list_top.
`timescale 1ns / 1ps

module tb;
  import bal_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int TAIL_CYCLES  = CAPACITY + 8;
  localparam int MAX_PRINTS   = 200;

  // Codes 10 to 15 carry no operation.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd10;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

  typedef struct packed {
    status_t           status;
    logic [FIDX_W-1:0] found_index;
    logic              found;
    logic [CNT_W-1:0]  count;
  } list_resp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic [OP_W-1:0]   s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  // Shadow copy of the list and the responses still to come.
  logic [VAL_W-1:0]  shadow_vals [CAPACITY];
  int                shadow_len = 0;
  list_resp_t        pending_resp_q [$];

  logic [VAL_W-1:0]  value_pool [8];
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                error_count = 0;
  int                request_count = 0;
  int                checked_count = 0;
  int                cycle_count = 0;
  int                status_hits [5] = '{0, 0, 0, 0, 0};

  bounded_array_list_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Remove the entry at the given index and close the gap.
  function automatic void shadow_drop(input int at);
    int k;
    for (k = at; k + 1 < shadow_len; k++) shadow_vals[k] = shadow_vals[k + 1];
    shadow_len--;
  endfunction

  // Index of the first entry equal to the value, or the length when absent.
  function automatic int shadow_first_match(input logic [VAL_W-1:0] value);
    int k;
    for (k = 0; k < shadow_len; k++) begin
      if (shadow_vals[k] == value) return k;
    end
    return shadow_len;
  endfunction

  // Apply one request to the shadow list and work out its response.
  function automatic list_resp_t predict_list_op(input logic [OP_W-1:0] op,
                                                 input logic [VAL_W-1:0] value,
                                                 input logic [POS_W-1:0] pos);
    list_resp_t r;
    int k;
    int w;
    r.status      = ST_OK;
    r.found_index = '0;
    r.found       = 1'b0;
    case (op)
      OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
        if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (op == OP_INSERT && int'(pos) > shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          w = (op == OP_PUSH_BACK) ? shadow_len : (op == OP_PUSH_FRONT) ? 0 : int'(pos);
          for (k = shadow_len; k > w; k--) shadow_vals[k] = shadow_vals[k - 1];
          shadow_vals[w] = value;
          shadow_len++;
        end
      end
      OP_POP_BACK: begin
        if (shadow_len == 0) r.status = ST_EMPTY;
        else shadow_len--;
      end
      OP_POP_FRONT, OP_ERASE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_ERASE && int'(pos) >= shadow_len) begin
          r.status = ST_BADPOS;
        end else begin
          shadow_drop((op == OP_ERASE) ? int'(pos) : 0);
        end
      end
      OP_FIND: begin
        k = shadow_first_match(value);
        if (k < shadow_len) begin
          r.found       = 1'b1;
          r.found_index = FIDX_W'(k);
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      OP_REMOVE_FIRST: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          k = shadow_first_match(value);
          if (k < shadow_len) begin
            r.found = 1'b1;
            shadow_drop(k);
          end else begin
            r.status = ST_NOTFOUND;
          end
        end
      end
      OP_REMOVE_ALL: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Compact the survivors in order.
          w = 0;
          for (k = 0; k < shadow_len; k++) begin
            if (shadow_vals[k] != value) begin
              shadow_vals[w] = shadow_vals[k];
              w++;
            end
          end
          if (w == shadow_len) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.found    = 1'b1;
            shadow_len = w;
          end
        end
      end
      OP_CLEAR: shadow_len = 0;
      default: ;
    endcase
    r.count = CNT_W'(shadow_len);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (error_count < MAX_PRINTS) begin
      $display("[%0t] mismatch on response %0d: %s got %0d, expected %0d",
               $time, checked_count, what, got, want);
    end
    error_count++;
  endtask

  // Send one request, waiting out any random idle gap first.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                              input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{(IN_W - POS_W - VAL_W){1'b0}}, pos, value};
    do @(posedge clk); while (!s_tready);
    pending_resp_q.push_back(predict_list_op(op, value, pos));
    request_count++;
  endtask

  // Compare every accepted response with the oldest prediction.
  always @(posedge clk) begin
    list_resp_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_resp_q.size() == 0) begin
        report_mismatch("response with no request outstanding", 32'(m_tdata), 32'd0);
      end else begin
        want = pending_resp_q.pop_front();
        if (m_tdata[2:0] !== want.status)
          report_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
        if (m_tdata[8:3] !== want.found_index)
          report_mismatch("found_index", 32'(m_tdata[8:3]), 32'(want.found_index));
        if (m_tdata[9] !== want.found)
          report_mismatch("found", 32'(m_tdata[9]), 32'(want.found));
        if (m_tdata[16:10] !== want.count)
          report_mismatch("count", 32'(m_tdata[16:10]), 32'(want.count));
        if (int'(want.status) < 5) status_hits[want.status]++;
      end
      checked_count++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, pending_resp_q.size());
      $display("** bounded_array_list_top: FAILED **");
      $finish;
    end
  end

  // Error paths on an empty list, then edge positions and extreme values.
  task automatic test_directed_cases();
    send_request(OP_POP_BACK, '0, '0);
    send_request(OP_POP_FRONT, '0, '0);
    send_request(OP_ERASE, '0, '0);
    send_request(OP_FIND, 32'd5, '0);
    send_request(OP_REMOVE_FIRST, 32'd5, '0);
    send_request(OP_REMOVE_ALL, 32'd5, '0);
    send_request(OP_INSERT, 32'd7, 7'd1);
    send_request(OP_INSERT, 32'h8000_0000, 7'd0);
    send_request(OP_PUSH_BACK, 32'h7FFF_FFFF, '0);
    send_request(OP_PUSH_FRONT, 32'h0000_0000, '0);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 7'd3);
    send_request(OP_FIND, 32'h7FFF_FFFF, '0);
    send_request(OP_FIND, 32'd12345, '0);
    send_request(OP_ERASE, '0, 7'd4);
    send_request(OP_ERASE, '0, 7'h7F);
    send_request(OP_PUSH_BACK, 32'hFFFF_FFFF, '0);
    send_request(OP_REMOVE_FIRST, 32'hFFFF_FFFF, '0);
    send_request(OP_REMOVE_FIRST, 32'd12345, '0);
    send_request(OP_PUSH_FRONT, 32'hFFFF_FFFF, '0);
    send_request(OP_REMOVE_ALL, 32'hFFFF_FFFF, '0);
    send_request(OP_REMOVE_ALL, 32'hFFFF_FFFF, '0);
    send_request(OP_ERASE, '0, 7'd1);
    send_request(OP_UNUSED_LO, 32'hFFFF_FFFF, 7'h7F);
    send_request(OP_UNUSED_HI, 32'hFFFF_FFFF, 7'h7F);
    send_request(OP_CLEAR, '0, '0);
  endtask

  // Fill the list to capacity and knock on every full-list path.
  task automatic test_fill_to_capacity();
    while (shadow_len < CAPACITY) send_request(OP_PUSH_BACK, $urandom(), POS_W'($urandom()));
    send_request(OP_PUSH_BACK, $urandom(), '0);
    send_request(OP_PUSH_FRONT, $urandom(), '0);
    send_request(OP_INSERT, $urandom(), POS_W'(CAPACITY));
    send_request(OP_INSERT, $urandom(), 7'd0);
    send_request(OP_FIND, shadow_vals[CAPACITY - 1], '0);
    send_request(OP_ERASE, '0, POS_W'(CAPACITY));
    send_request(OP_ERASE, '0, POS_W'(CAPACITY - 1));
    send_request(OP_INSERT, $urandom(), POS_W'(CAPACITY - 1));
    send_request(OP_REMOVE_FIRST, shadow_vals[CAPACITY - 1], '0);
    send_request(OP_CLEAR, '0, '0);
  endtask

  // Random requests that swing the list between empty and full.
  task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
    int i;
    int pick;
    bit grow;
    logic [OP_W-1:0]  op;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    grow = 1'b1;
    for (i = 0; i < n_items; i++) begin
      if (shadow_len >= CAPACITY) grow = 1'b0;
      else if (shadow_len == 0) grow = 1'b1;
      else if ($urandom_range(63) == 0) grow = ~grow;
      pick = $urandom_range(99);
      if (pick < 1) begin
        op = OP_CLEAR;
      end else if (pick < 4) begin
        op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end else if (pick < 60 && grow) begin
        case ($urandom_range(2))
          0:       op = OP_PUSH_BACK;
          1:       op = OP_PUSH_FRONT;
          default: op = OP_INSERT;
        endcase
      end else if (pick < 60) begin
        case ($urandom_range(4))
          0:       op = OP_POP_BACK;
          1:       op = OP_POP_FRONT;
          2:       op = OP_ERASE;
          3:       op = OP_REMOVE_FIRST;
          default: op = OP_REMOVE_ALL;
        endcase
      end else begin
        op = OP_W'($urandom_range(OP_REMOVE_ALL));
      end
      // Mostly pool values so that finds and removes hit; the rest anything.
      value = ($urandom_range(9) < 7) ? value_pool[$urandom_range(7)] : $urandom();
      pos = ($urandom_range(9) < 8) ? POS_W'($urandom_range(shadow_len)) : POS_W'($urandom());
      send_request(op, value, pos);
    end
  endtask

  // Stop sending and let every outstanding response come back.
  task automatic wait_for_responses();
    s_tvalid <= 1'b0;
    while (pending_resp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  initial begin
    int k;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    for (k = 5; k < 8; k++) value_pool[k] = $urandom();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_fill_to_capacity();
    test_random_traffic(365, 0, 0);
    test_random_traffic(365, 54, 0);
    test_random_traffic(365, 0, 54);
    test_random_traffic(365, 26, 26);
    wait_for_responses();

    $display("Sent %0d requests and checked %0d responses in %0d cycles, %0d mismatches.",
             request_count, checked_count, cycle_count, error_count);
    $display("Status seen: ok %0d, full %0d, empty %0d, bad position %0d, not found %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (error_count == 0) begin
      $display("** bounded_array_list_top: PASSED **");
    end else begin
      $display("** bounded_array_list_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: bounded_array_list_top.f
rtl/bal_pkg.sv
rtl/bal_ram.sv
rtl/bounded_array_list_top.sv
rtl/bal_checker.sv
tb/sv/tb.sv
